FILE: hdl/llc_pkg.sv
// Shared constants, widths and the arctangent table for the position converter.
// No dependencies; every other file imports this package.
`default_nettype none
package llc_pkg;
	localparam int LAT_W = 28;
	localparam int LON_W = 29;
	localparam int ALT_W = 24;
	localparam int POS_W = 30;

	// angle magnitude, phase and CORDIC datapath widths
	localparam int MAG_W = 29;
	localparam int PH_W = 32;
	localparam int ZW = 34;
	localparam int CW = 33;
	localparam int R16_W = 29;

	// phase = floor((mag*512 + 22) / 45), split as mag = 45*h + rem
	localparam int DIV_K = 45;
	localparam int DIV_K_W = 6;
	localparam int FRAC_SH = 9;
	localparam int HALF_OFF = 22;
	localparam int H_W = 23;
	localparam int RECIP_W = 30;
	localparam logic [RECIP_W-1:0] RECIP = 30'd763549742;
	localparam int RECIP_SH = 35;
	localparam int T_W = 15;
	localparam int RREC_W = 16;
	localparam logic [RREC_W-1:0] REM_RECIP = 16'd46604;
	localparam int REM_SH = 21;

	localparam int TRIG_ITERATIONS = 24;
	localparam int CORDIC_N = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam int EARTH_RADIUS_M = 6371000;
	localparam int RAD_W = 25;

	localparam int PHASE_LAT = 4;
	localparam int CORDIC_LAT = CORDIC_N + 2;
	localparam int SCALE_LAT = 2;

	function automatic logic [PH_W-1:0] atan_phase(input int i);
		logic [PH_W-1:0] v;
		unique case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/llc_phase.sv
// Angle to folded CORDIC phase: four register stages, division by 360 degrees
// done with constant reciprocals. Depends on llc_pkg.
`default_nettype none
module llc_phase import llc_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [MAG_W-1:0] angle,
	output logic signed [ZW-1:0]    z,
	output logic                    flip
);
	logic [MAG_W-1:0] mag_s1, mag_s2;
	logic neg_s1, neg_s2, neg_s3;
	logic [MAG_W+RECIP_W-1:0] prod_s2;
	logic [H_W-1:0] h_s3;
	logic [FRAC_SH-1:0] q_s3;
	logic signed [ZW-1:0] z_s4;
	logic flip_s4;

	logic [H_W-1:0] h;
	logic [MAG_W-1:0] hk;
	logic [DIV_K_W-1:0] rem;
	logic [T_W-1:0] t;
	logic [T_W+RREC_W-1:0] tq;
	logic [PH_W-1:0] p, pn, pf;

	always_comb begin
		h = prod_s2[RECIP_SH +: H_W];
		hk = MAG_W'({{(MAG_W-H_W){1'b0}}, h} * MAG_W'(DIV_K));
		rem = DIV_K_W'(mag_s2 - hk);
		t = T_W'({rem, {FRAC_SH{1'b0}}}) + T_W'(HALF_OFF);
		tq = {{RREC_W{1'b0}}, t} * {{T_W{1'b0}}, REM_RECIP};
		p = {h_s3, q_s3};
		pn = neg_s3 ? (~p + 1'b1) : p;
		// fold into the right half plane; llc_cordic negates both results
		pf = pn + 32'h4000_0000;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= angle[MAG_W-1];
			mag_s1 <= angle[MAG_W-1] ? MAG_W'(-angle) : MAG_W'(angle);
			prod_s2 <= {{RECIP_W{1'b0}}, mag_s1} * {{MAG_W{1'b0}}, RECIP};
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			h_s3 <= h;
			q_s3 <= tq[REM_SH +: FRAC_SH];
			neg_s3 <= neg_s2;
			flip_s4 <= pf[PH_W-1];
			z_s4 <= ZW'(signed'({pn[PH_W-1] ^ pf[PH_W-1], pn[PH_W-2:0]}));
		end
	end

	assign z = z_s4;
	assign flip = flip_s4;
endmodule
`default_nettype wire

FILE: hdl/llc_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, plus input and
// output registers. Depends on llc_pkg.
`default_nettype none
module llc_cordic import llc_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [ZW-1:0] z,
	input  logic                 flip,
	output logic signed [CW-1:0] sin_v,
	output logic signed [CW-1:0] cos_v
);
	logic signed [CW-1:0] cx_s [0:CORDIC_N];
	logic signed [CW-1:0] cy_s [0:CORDIC_N];
	logic signed [ZW-1:0] cz_s [0:CORDIC_N];
	logic cf_s [0:CORDIC_N];
	logic signed [CW-1:0] sin_q, cos_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= z;
			cf_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN = ZW'(atan_phase(i));
		logic signed [CW-1:0] xs, ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][ZW-1]) begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - ATAN;
				end else begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + ATAN;
				end
				cf_s[i+1] <= cf_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= cf_s[CORDIC_N] ? -cx_s[CORDIC_N] : cx_s[CORDIC_N];
			sin_q <= cf_s[CORDIC_N] ? -cy_s[CORDIC_N] : cy_s[CORDIC_N];
		end
	end

	assign sin_v = sin_q;
	assign cos_v = cos_q;
endmodule
`default_nettype wire

FILE: hdl/llc_scale.sv
// Radius scaling: two multiply stages with round-half-up Q30 products.
// Depends on llc_pkg.
`default_nettype none
module llc_scale import llc_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [R16_W-1:0]     r16,
	input  logic signed [CW-1:0] sin_lat,
	input  logic signed [CW-1:0] cos_lat,
	input  logic signed [CW-1:0] sin_lon,
	input  logic signed [CW-1:0] cos_lon,
	output logic signed [CW-1:0] px,
	output logic signed [CW-1:0] py,
	output logic signed [CW-1:0] pz
);
	function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b + (2*CW)'(64'sd1 <<< 29);
		return CW'(p >>> 30);
	endfunction

	logic signed [CW-1:0] rv, rc_s1, pz_s1, sl_s1, cl_s1, px_s2, py_s2, pz_s2;

	assign rv = CW'(signed'({1'b0, r16}));

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s1 <= mul_q30(rv, cos_lat);
			pz_s1 <= mul_q30(rv, sin_lat);
			sl_s1 <= sin_lon;
			cl_s1 <= cos_lon;
			px_s2 <= mul_q30(rc_s1, cl_s1);
			py_s2 <= mul_q30(rc_s1, sl_s1);
			pz_s2 <= pz_s1;
		end
	end

	assign px = px_s2;
	assign py = py_s2;
	assign pz = pz_s2;
endmodule
`default_nettype wire

FILE: hdl/lat_lon_alt_to_cartesian.sv
// Latitude/longitude/altitude to Cartesian position on a sphere.
// Path: llc_phase, llc_cordic (24 iterations by default), llc_scale and a clamping
// output register; throughput one word per cycle, set by the fully pipelined CORDIC,
// while no output word is stalled. A stalled output word freezes the whole pipeline.
// Reset clears the valid bits only. Depends on llc_pkg, llc_phase, llc_cordic, llc_scale.
`default_nettype none
module lat_lon_alt_to_cartesian import llc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [LAT_W-1:0] latitude,
	input  logic signed [LON_W-1:0] longitude,
	input  logic [ALT_W-1:0]        altitude,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z
);
	localparam int R_DLY = PHASE_LAT + CORDIC_LAT;
	localparam int TOT = R_DLY + SCALE_LAT + 1;

	function automatic logic signed [POS_W-1:0] clamp(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi, lo;
		hi = CW'((64'sd1 <<< (POS_W-1)) - 1);
		lo = CW'(-(64'sd1 <<< (POS_W-1)));
		priority if (v > hi) return POS_W'(hi);
		else if (v < lo) return POS_W'(lo);
		else return POS_W'(v);
	endfunction

	logic en;
	logic [TOT-1:0] valid_q;
	logic [R16_W-1:0] r16_q [0:R_DLY-1];
	logic [R16_W-1:0] r16;
	logic signed [ZW-1:0] zlat, zlon;
	logic flat, flon;
	logic signed [CW-1:0] slat, clat, slon, clon, px, py, pz;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;

	assign en = !(valid_q[TOT-1] && out_stall);
	assign in_stall = !en;
	assign r16 = R16_W'({{(RAD_W-ALT_W){1'b0}}, altitude} + RAD_W'(EARTH_RADIUS_M)) << 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[TOT-2:0], in_valid};
		end
	end

	// radius travels alongside the angle pipelines
	always_ff @(posedge clk) begin
		if (en) begin
			r16_q[0] <= r16;
			for (int i = 1; i < R_DLY; i++) r16_q[i] <= r16_q[i-1];
			px_q <= clamp(px);
			py_q <= clamp(py);
			pz_q <= clamp(pz);
		end
	end

	llc_phase u_ph_lat (.clk, .en, .angle({latitude[LAT_W-1], latitude}), .z(zlat), .flip(flat));
	llc_phase u_ph_lon (.clk, .en, .angle(longitude), .z(zlon), .flip(flon));
	llc_cordic u_cd_lat (.clk, .en, .z(zlat), .flip(flat), .sin_v(slat), .cos_v(clat));
	llc_cordic u_cd_lon (.clk, .en, .z(zlon), .flip(flon), .sin_v(slon), .cos_v(clon));
	llc_scale u_scale (.clk, .en, .r16(r16_q[R_DLY-1]), .sin_lat(slat), .cos_lat(clat),
		.sin_lon(slon), .cos_lon(clon), .px, .py, .pz);

	assign out_valid = valid_q[TOT-1];
	assign pos_x = px_q;
	assign pos_y = py_q;
	assign pos_z = pz_q;

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_q)) else $error("pipeline moved during stall");
	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_q[TOT-2] |=> out_valid) else $error("word lost before output");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && !valid_q[TOT-2] |=> !out_valid) else $error("word repeated at output");
endmodule
`default_nettype wire

FILE: dv/tb_lat_lon_alt_to_cartesian.sv
// Self-checking bench for lat_lon_alt_to_cartesian: drives position words, predicts
// x/y/z through a bit-exact CORDIC and rounding model, checks every result in order.
// Depends on llc_pkg and the block's RTL.
module tb_lat_lon_alt_to_cartesian;
	import llc_pkg::*;

	localparam int LAT_MAX = 94371840;
	localparam int LON_MAX = 188743680;
	localparam int N_RANDOM = 1530;
	localparam int SETTLE_CYCLES = 48;

	localparam int ANGLE_SHIFT = 20;
	logic [31:0] atan_table [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0};

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} coord_t;

	class position_scoreboard;
		coord_t pending[$];
		int errors = 0;

		static function longint unsigned angle_to_phase(longint a);
			longint unsigned mag, div, q;
			mag = (a < 0) ? -a : a;
			div = longint'(360) << ANGLE_SHIFT;
			q = ((mag << 32) + (div >> 1)) / div;
			if (a < 0)
				q = -q;
			return q & 64'hFFFF_FFFF;
		endfunction

		static function void sin_cos(logic [31:0] p, output longint s, output longint c);
			logic [31:0] folded;
			logic flip;
			longint x, y, z, t;
			folded = p + 32'h4000_0000;
			flip = folded >= 32'h8000_0000;
			if (flip)
				p = p + 32'h8000_0000;
			x = 652032874;
			y = 0;
			z = longint'(signed'(p));
			for (int i = 0; i < CORDIC_N; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z = z - longint'(atan_table[i]);
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z = z + longint'(atan_table[i]);
				end
				x = t;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		static function longint scale_q30(longint a, longint b);
			return (a * b + (longint'(1) << 29)) >>> 30;
		endfunction

		static function logic signed [POS_W-1:0] clamp(longint v);
			longint hi, lo;
			hi = (longint'(1) << (POS_W - 1)) - 1;
			lo = -(longint'(1) << (POS_W - 1));
			if (v > hi)
				v = hi;
			if (v < lo)
				v = lo;
			return v[POS_W-1:0];
		endfunction

		function void note(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
				logic [ALT_W-1:0] alt);
			longint slat, clat, slon, clon, r16, rc;
			coord_t e;
			r16 = (longint'(alt) + EARTH_RADIUS_M) * 16;
			sin_cos(angle_to_phase(longint'(lat)), slat, clat);
			sin_cos(angle_to_phase(longint'(lon)), slon, clon);
			rc = scale_q30(r16, clat);
			e.x = clamp(scale_q30(rc, clon));
			e.y = clamp(scale_q30(rc, slon));
			e.z = clamp(scale_q30(r16, slat));
			pending.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
				logic signed [POS_W-1:0] z);
			coord_t e;
			if (pending.size() == 0) begin
				report("unexpected word x", x, 0);
				return;
			end
			e = pending.pop_front();
			if (x !== e.x)
				report("pos_x", x, e.x);
			if (y !== e.y)
				report("pos_y", y, e.y);
			if (z !== e.z)
				report("pos_z", z, e.z);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [LAT_W-1:0] latitude = '0;
	logic signed [LON_W-1:0] longitude = '0;
	logic [ALT_W-1:0] altitude = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;

	position_scoreboard sb = new();
	int words_sent = 0;
	logic hold_request = 0;

	lat_lon_alt_to_cartesian u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.latitude(latitude), .longitude(longitude), .altitude(altitude),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#3200000;
		$display("tb_lat_lon_alt_to_cartesian: FAIL");
		$finish;
	end

	// offer one word and hold it until accepted
	task send_position(int lat, int lon, int alt);
		@(negedge clk);
		in_valid = 1;
		latitude = LAT_W'(lat);
		longitude = LON_W'(lon);
		altitude = ALT_W'(alt);
		do
			@(posedge clk);
		while (in_stall);
		sb.note(latitude, longitude, altitude);
		words_sent++;
	endtask

	task idle_sender(int cycles);
		@(negedge clk);
		in_valid = 0;
		repeat (cycles)
			@(negedge clk);
	endtask

	task send_random;
		int lat, lon, alt;
		if ($urandom_range(0, 9) == 0) begin
			lat = $urandom;
			lon = $urandom;
			lat = (lat << 4) >>> 4;
			lon = (lon << 3) >>> 3;
		end else begin
			lat = int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
			lon = int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
		end
		alt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : $urandom & 24'hFF_FFFF;
		send_position(lat, lon, alt);
	endtask

	// receiver: stall patterns change every stretch, with a long hold-off on request
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 150)) begin
				@(negedge clk);
				if (hold_request) begin
					out_stall = 1;
					repeat (300)
						@(negedge clk);
					hold_request = 0;
				end
				case (mode)
					0: out_stall = 0;
					1: out_stall = ($urandom_range(0, 9) < 3);
					2: out_stall = ($urandom_range(0, 9) < 7);
					default: out_stall = ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(pos_x, pos_y, pos_z);
	end

	initial begin
		int burst;
		bit held_off;
		bit drained;
		held_off = 0;
		drained = 0;
		repeat (2)
			@(negedge clk);
		arst_n = 1;

		// directed: angle extremes, quadrant edges, out-of-range angles, altitude ends
		send_position(0, 0, 0);
		send_position(LAT_MAX, 0, 0);
		send_position(-LAT_MAX, 0, 24'hFF_FFFF);
		send_position(0, LON_MAX, 0);
		send_position(0, -LON_MAX, 24'hFF_FFFF);
		send_position(0, LON_MAX / 2, 1000);
		send_position(0, -LON_MAX / 2, 1000);
		send_position(LAT_MAX / 2, LON_MAX / 4, 8848);
		send_position(-LAT_MAX / 2, -LON_MAX / 4, 123456);
		send_position(LAT_MAX, LON_MAX, 24'hFF_FFFF);
		send_position(-LAT_MAX, -LON_MAX, 0);
		send_position(-(1 << 27), -(1 << 28), 24'hFF_FFFF);
		send_position((1 << 27) - 1, (1 << 28) - 1, 0);
		send_position(1, -1, 1);
		send_position(-1, 1, 24'hAA_AAAA);
		send_position(LAT_MAX + 1, LON_MAX + 1, 24'h55_5555);
		send_position(-LAT_MAX - 1, -LON_MAX - 1, 42);
		send_position(LAT_MAX / 3, LON_MAX * 3 / 4, 500000);
		send_position(-LAT_MAX / 3, -LON_MAX * 3 / 4, 9999999);
		send_position(32'h0AAA_AAAA >>> 0, 29'h0AAA_AAAA, 24'h80_0000);

		while (words_sent < N_RANDOM + 20) begin
			if (!held_off && words_sent > 400) begin
				hold_request = 1;
				held_off = 1;
			end
			if (!drained && words_sent > 800) begin
				drained = 1;
				idle_sender(0);
				wait (sb.pending.size() == 0);
			end
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_random();
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 12));
		end
		idle_sender(0);
		wait (sb.pending.size() == 0);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_lat_lon_alt_to_cartesian: PASS");
		else
			$display("tb_lat_lon_alt_to_cartesian: FAIL");
		$finish;
	end
endmodule

FILE: lat_lon_alt_to_cartesian.f
hdl/llc_pkg.sv
hdl/llc_phase.sv
hdl/llc_cordic.sv
hdl/llc_scale.sv
hdl/lat_lon_alt_to_cartesian.sv
dv/tb_lat_lon_alt_to_cartesian.sv
